// ===== src/rmps_pkg.sv =====
// Shared types and constants for the RGB matrix PWM scan driver.
// No dependencies; imported by every module of the block.
package rmps_pkg;

  localparam int COLUMNS     = 64;
  localparam int SUBMATRICES = 2;
  localparam int SUBROWS     = 8;
  localparam int ROWS        = SUBMATRICES * SUBROWS;
  localparam int COL_W       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ADDR_W      = 3 + COL_W;
  localparam int DEPTH       = 1 << ADDR_W;
  localparam int VIS_SUB     = (SUBMATRICES < 2) ? SUBMATRICES : 2;

  localparam logic [7:0] PHASE_END = 8'hff;
  localparam logic [2:0] LAST_SUBROW = 3'd7;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [3:0] pixel_row;
    logic [5:0] pixel_col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [2:0] row_select;
    logic [5:0] serial_bits;
    logic [5:0] shift_column;
    logic       latch;
    logic [7:0] pwm_phase;
  } out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic              en;
    logic [1:0]        bank;
    logic [ADDR_W-1:0] addr;
    pixel_t            data;
  } mem_wr_t;

endpackage

// ===== src/rmps_frame_store.sv =====
// Frame store: one synchronous RAM per submatrix, registered read port,
// and the clearing sweep that zeroes every entry after reset. Uses rmps_pkg.
module rmps_frame_store (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  rmps_pkg::mem_wr_t                          wr,
  input  logic                                       rd_en,
  input  logic [rmps_pkg::ADDR_W-1:0]                rd_addr,
  output rmps_pkg::pixel_t [rmps_pkg::SUBMATRICES-1:0] rd_data,
  output logic                                       busy
);
  import rmps_pkg::*;

  logic [ADDR_W:0] clr_r;

  assign busy = !clr_r[ADDR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (busy) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  for (genvar g = 0; g < SUBMATRICES; g++) begin : g_bank
    pixel_t mem [DEPTH];
    pixel_t rd_q_r;

    always_ff @(posedge clk) begin
      if (busy) begin
        mem[clr_r[ADDR_W-1:0]] <= '0;
      end else if (wr.en && wr.bank == 2'(g)) begin
        mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
        rd_q_r <= mem[rd_addr];
      end
    end

    assign rd_data[g] = rd_q_r;
  end

endmodule

// ===== src/rgb_matrix_pwm_scan_top.sv =====
// Top level of the RGB matrix PWM scan driver: scan counters, compare stage
// and output register. Uses rmps_pkg and rmps_frame_store.
//
// One transaction per cycle on the input, write or scan alike, as long as the
// output is taken. A scan transaction reads the frame RAMs and loads the
// compare stage at the edge that accepts it; its result is then loaded into
// the output register once that register is free. The rate is set by the
// single read port of each frame RAM (one pixel per submatrix per cycle).
// in_ready drops while a scan result waits in the compare stage behind a
// stalled output register. After reset the frame store runs a clearing
// sweep over all DEPTH = 8 * 2^COL_W entries (512 with 64 columns), during
// which in_ready stays low.
module rgb_matrix_pwm_scan_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmps_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rmps_pkg::out_t out_data
);
  import rmps_pkg::*;

  logic [2:0]       subrow_r;
  logic [COL_W-1:0] col_r;
  logic [7:0]       phase_r;
  logic [7:0]       phase_nxt;

  logic             s1_valid_r;
  logic [2:0]       s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_latch_r;
  logic [7:0]       s1_phase_r;

  logic             out_valid_r;
  out_t             out_data_r;

  logic             busy;
  logic             stall;
  logic             in_fire;
  logic             scan_fire;
  logic             last_col;
  mem_wr_t          wr;
  pixel_t [SUBMATRICES-1:0] rd_data;
  logic [5:0]       bits;

  assign stall     = s1_valid_r && out_valid_r && !out_ready;
  assign in_ready  = !busy && !stall;
  assign in_fire   = in_valid && in_ready;
  assign scan_fire = in_fire && in_data.kind == KIND_SCAN;
  assign last_col  = col_r == '0;

  always_comb begin
    wr.en   = in_fire && in_data.kind == KIND_WRITE &&
              32'(in_data.pixel_row) < ROWS && 32'(in_data.pixel_col) < COLUMNS;
    wr.bank = {1'b0, in_data.pixel_row[3]};
    wr.addr = {in_data.pixel_row[2:0], COL_W'(in_data.pixel_col)};
    wr.data = '{red: in_data.red, green: in_data.green, blue: in_data.blue};
  end

  rmps_frame_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (scan_fire),
    .rd_addr ({subrow_r, col_r}),
    .rd_data (rd_data),
    .busy    (busy)
  );

  always_comb begin
    phase_nxt = phase_r + 8'd1;
    if (phase_nxt == PHASE_END) begin
      phase_nxt = '0;
    end
  end

  always_comb begin
    bits = '0;
    for (int s = 0; s < VIS_SUB; s++) begin
      bits[3*s]   = rd_data[s].red   > s1_phase_r;
      bits[3*s+1] = rd_data[s].green > s1_phase_r;
      bits[3*s+2] = rd_data[s].blue  > s1_phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subrow_r    <= '0;
      col_r       <= COL_W'(COLUMNS - 1);
      phase_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (scan_fire) begin
        if (last_col) begin
          col_r <= COL_W'(COLUMNS - 1);
          if (subrow_r == LAST_SUBROW) begin
            subrow_r <= '0;
            phase_r  <= phase_nxt;
          end else begin
            subrow_r <= subrow_r + 3'd1;
          end
        end else begin
          col_r <= col_r - 1'b1;
        end
      end
      if (!stall) begin
        s1_valid_r <= scan_fire;
      end
      if (!out_valid_r || out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_fire) begin
      s1_row_r   <= subrow_r;
      s1_col_r   <= col_r;
      s1_latch_r <= last_col;
      s1_phase_r <= phase_r;
    end
    if (!out_valid_r || out_ready) begin
      out_data_r.row_select   <= s1_row_r;
      out_data_r.serial_bits  <= bits;
      out_data_r.shift_column <= 6'(s1_col_r);
      out_data_r.latch        <= s1_latch_r;
      out_data_r.pwm_phase    <= s1_phase_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/rmps_checker.sv =====
// Port-level checker for the RGB matrix PWM scan driver, bound to the top.
// Uses rmps_pkg; watches only the ports of rgb_matrix_pwm_scan_top.
module rmps_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input rmps_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input rmps_pkg::out_t out_data
);
  import rmps_pkg::*;

  logic prev_seen_r;
  out_t prev_r;
  logic out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_seen_r <= 1'b0;
    end else if (out_fire) begin
      prev_seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      prev_r <= out_data;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transaction dropped or changed while waiting");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pwm_phase != PHASE_END)
    else $error("subframe reached the wrap value");

  a_row_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && prev_seen_r && !prev_r.latch |->
      out_data.row_select == prev_r.row_select &&
      out_data.pwm_phase == prev_r.pwm_phase)
    else $error("subrow or subframe moved before the latch");

endmodule

bind rgb_matrix_pwm_scan_top rmps_checker u_rmps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
